>>> rtl/core/script_header_parser_unit_assert.svh
// Assertion macros used by the script header parser RTL.
`ifndef SCRIPT_HEADER_PARSER_UNIT_ASSERT_SVH
`define SCRIPT_HEADER_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("script header parser: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("script header parser: next-cycle check failed");

`endif

>>> rtl/core/shp_pkg.sv
// Package: shared types and result codes of the script header parser.
`timescale 1ns / 1ps
package shp_pkg;

	localparam logic [1:0] RK_LOCAL   = 2'd0;
	localparam logic [1:0] RK_HEADER  = 2'd1;
	localparam logic [1:0] RK_TIMEOUT = 2'd2;

	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_TIMEOUT = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [7:0]         data_byte;
		logic signed [15:0] start_address;
		logic [7:0]         script_number;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         result_kind;
		logic [7:0]         local_position;
		logic [7:0]         local_value;
		logic               running;
		logic               once;
		logic [7:0]         interval;
		logic [7:0]         arg_count;
		logic [7:0]         local_count;
		logic [14:0]        instruction_count;
		logic signed [15:0] instruction_start;
		logic signed [15:0] instruction_stop;
		logic [7:0]         header_script;
	} result_t;

	// Handshake between the input stage and the result register.
	typedef struct packed {
		logic valid;
		logic advance;
	} stage_ctl_t;

endpackage

>>> rtl/core/shp_in_if.sv
// Interface: input byte channel of the script header parser.
`timescale 1ns / 1ps
interface shp_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [7:0]         data_byte;
	logic signed [15:0] start_address;
	logic [7:0]         script_number;

	modport source (output valid, kind, data_byte, start_address, script_number,
		input ready);
	modport sink (input valid, kind, data_byte, start_address, script_number,
		output ready);
endinterface

>>> rtl/core/shp_out_if.sv
// Interface: result channel of the script header parser.
`timescale 1ns / 1ps
interface shp_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         result_kind;
	logic [7:0]         local_position;
	logic [7:0]         local_value;
	logic               running;
	logic               once;
	logic [7:0]         interval;
	logic [7:0]         arg_count;
	logic [7:0]         local_count;
	logic [14:0]        instruction_count;
	logic signed [15:0] instruction_start;
	logic signed [15:0] instruction_stop;
	logic [7:0]         header_script;

	modport source (output valid, result_kind, local_position, local_value, running, once,
		interval, arg_count, local_count, instruction_count, instruction_start,
		instruction_stop, header_script, input ready);
	modport sink (input valid, result_kind, local_position, local_value, running, once,
		interval, arg_count, local_count, instruction_count, instruction_start,
		instruction_stop, header_script, output ready);
endinterface

>>> rtl/core/shp_in_stage.sv
// Input register stage: capture one transaction, hold it until the parser takes it.
`timescale 1ns / 1ps
module shp_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	shp_in_if.sink            stream,
	input  logic              advance,
	output shp_pkg::stage_ctl_t ctl_unused_guard,
	output shp_pkg::in_item_t item_s1
);
	import shp_pkg::*;

	logic valid_s1;
	logic take;

	assign stream.ready = !valid_s1 || advance;
	assign take         = stream.valid && stream.ready;

	assign ctl_unused_guard.valid   = valid_s1;
	assign ctl_unused_guard.advance = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.kind          <= stream.kind;
			item_s1.data_byte     <= stream.data_byte;
			item_s1.start_address <= stream.start_address;
			item_s1.script_number <= stream.script_number;
		end
	end
endmodule

>>> rtl/core/shp_parser.sv
// Header parser: phase register, latched header fields, result decode.
`timescale 1ns / 1ps
`include "script_header_parser_unit_assert.svh"
module shp_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  shp_pkg::in_item_t item,
	output logic              res_valid,
	output shp_pkg::result_t  res
);
	import shp_pkg::*;

	localparam logic [2:0] PH_FLAGS    = 3'd0;
	localparam logic [2:0] PH_INTERVAL = 3'd1;
	localparam logic [2:0] PH_ARGS     = 3'd2;
	localparam logic [2:0] PH_LCOUNT   = 3'd3;
	localparam logic [2:0] PH_LOCALS   = 3'd4;
	localparam logic [2:0] PH_CNT_HI   = 3'd5;
	localparam logic [2:0] PH_CNT_LO   = 3'd6;

	// flags: [4] running, [3] once, [2] has-interval, [1] has-args, [0] has-locals
	function automatic logic [2:0] after_phase(input logic [2:0] from, input logic [4:0] f);
		logic [2:0] nxt;
		priority if (from < PH_INTERVAL && f[2]) nxt = PH_INTERVAL;
		else if (from < PH_ARGS && f[1])         nxt = PH_ARGS;
		else if (from < PH_LCOUNT && f[0])       nxt = PH_LCOUNT;
		else                                     nxt = PH_CNT_HI;
		return nxt;
	endfunction

	logic [2:0]  phase_q, phase_d;
	logic [4:0]  flag_bits_q, flag_bits_d;
	logic [15:0] start_q, start_d;
	logic [7:0]  script_q, script_d;
	logic [7:0]  interval_q, interval_d;
	logic [7:0]  args_q, args_d;
	logic [7:0]  locals_total_q, locals_total_d;
	logic [7:0]  locals_seen_q, locals_seen_d;
	logic [6:0]  count_high_q, count_high_d;

	logic [7:0]  b;
	logic [7:0]  seen_inc;
	logic [14:0] hdr_count;
	logic [15:0] hdr_stop;
	result_t     header;

	logic        timeout_fire;
	logic        header_fire;
	logic        local_out;
	logic        in_list;

	assign b         = item.data_byte;
	assign seen_inc  = locals_seen_q + 8'd1;
	assign hdr_count = (phase_q == PH_CNT_LO) ? {count_high_q, b} : {7'd0, b};
	assign hdr_stop  = start_q + {1'b0, hdr_count} - 16'd1;

	always_comb begin
		header                   = '0;
		header.result_kind       = RK_HEADER;
		header.running           = flag_bits_q[4];
		header.once              = flag_bits_q[3];
		header.interval          = interval_q;
		header.arg_count         = args_q;
		header.local_count       = locals_total_q;
		header.instruction_count = hdr_count;
		header.instruction_start = start_q;
		header.instruction_stop  = hdr_stop;
		header.header_script     = script_q;
	end

	always_comb begin
		phase_d        = phase_q;
		flag_bits_d    = flag_bits_q;
		start_d        = start_q;
		script_d       = script_q;
		interval_d     = interval_q;
		args_d         = args_q;
		locals_total_d = locals_total_q;
		locals_seen_d  = locals_seen_q;
		count_high_d   = count_high_q;
		res_valid      = 1'b0;
		res            = '0;
		if (item.kind == KIND_TIMEOUT) begin
			// abort the header wherever it stands
			res_valid       = 1'b1;
			res.result_kind = RK_TIMEOUT;
			phase_d         = PH_FLAGS;
		end else begin
			unique case (phase_q)
				PH_INTERVAL: begin
					interval_d = b;
					phase_d    = after_phase(PH_INTERVAL, flag_bits_q);
				end
				PH_ARGS: begin
					args_d  = b;
					phase_d = after_phase(PH_ARGS, flag_bits_q);
				end
				PH_LCOUNT: begin
					locals_total_d = b;
					locals_seen_d  = 8'd0;
					phase_d        = (b != 8'd0) ? PH_LOCALS : PH_CNT_HI;
				end
				PH_LOCALS: begin
					res_valid          = 1'b1;
					res.result_kind    = RK_LOCAL;
					res.local_position = locals_seen_q;
					res.local_value    = b;
					locals_seen_d      = seen_inc;
					if (seen_inc == locals_total_q) begin
						phase_d = PH_CNT_HI;
					end
				end
				PH_CNT_HI: begin
					if (b[7]) begin
						count_high_d = b[6:0];
						phase_d      = PH_CNT_LO;
					end else begin
						res_valid = 1'b1;
						res       = header;
						phase_d   = PH_FLAGS;
					end
				end
				PH_CNT_LO: begin
					res_valid = 1'b1;
					res       = header;
					phase_d   = PH_FLAGS;
				end
				default: begin
					// flags byte; the unused phase code lands here too
					flag_bits_d    = b[7:3];
					start_d        = item.start_address;
					script_d       = item.script_number;
					interval_d     = 8'd0;
					args_d         = 8'd0;
					locals_total_d = 8'd0;
					locals_seen_d  = 8'd0;
					count_high_d   = 7'd0;
					phase_d        = after_phase(PH_FLAGS, b[7:3]);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_FLAGS;
			flag_bits_q    <= '0;
			start_q        <= '0;
			script_q       <= '0;
			interval_q     <= '0;
			args_q         <= '0;
			locals_total_q <= '0;
			locals_seen_q  <= '0;
			count_high_q   <= '0;
		end else if (fire) begin
			phase_q        <= phase_d;
			flag_bits_q    <= flag_bits_d;
			start_q        <= start_d;
			script_q       <= script_d;
			interval_q     <= interval_d;
			args_q         <= args_d;
			locals_total_q <= locals_total_d;
			locals_seen_q  <= locals_seen_d;
			count_high_q   <= count_high_d;
		end
	end

	assign timeout_fire = fire && (item.kind == KIND_TIMEOUT);
	assign header_fire  = fire && res_valid && (res.result_kind == RK_HEADER);
	assign local_out    = res_valid && (res.result_kind == RK_LOCAL);
	assign in_list      = (phase_q == PH_LOCALS);

	`SHP_ASSERT_NEXT(a_timeout_to_flags, clk, arst_n, timeout_fire, phase_q == PH_FLAGS)
	`SHP_ASSERT_NEXT(a_header_to_flags, clk, arst_n, header_fire, phase_q == PH_FLAGS)
	`SHP_ASSERT_SAME(a_local_in_list, clk, arst_n, local_out, in_list)
	`SHP_ASSERT_SAME(a_seen_below_total, clk, arst_n, in_list, locals_seen_q < locals_total_q)
endmodule

>>> rtl/core/shp_out_reg.sv
// Result register: hold one result transaction until the receiver takes it.
`timescale 1ns / 1ps
module shp_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  shp_pkg::result_t res,
	output logic             free,
	shp_out_if.source        report
);
	import shp_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || report.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

	assign report.valid             = valid_q;
	assign report.result_kind       = res_q.result_kind;
	assign report.local_position    = res_q.local_position;
	assign report.local_value       = res_q.local_value;
	assign report.running           = res_q.running;
	assign report.once              = res_q.once;
	assign report.interval          = res_q.interval;
	assign report.arg_count         = res_q.arg_count;
	assign report.local_count       = res_q.local_count;
	assign report.instruction_count = res_q.instruction_count;
	assign report.instruction_start = res_q.instruction_start;
	assign report.instruction_stop  = res_q.instruction_stop;
	assign report.header_script     = res_q.header_script;
endmodule

>>> rtl/core/script_header_parser_unit.sv
// Script header parser unit: top level.
// Usage:
//  - stream (sink): one transaction per header byte, kind selects data byte or
//    reader timeout; start_address and script_number are sampled with the
//    flags byte only.
//  - report (source): local entries, completed headers and timeout errors,
//    at most one result transaction per input transaction.
//  - Path: a transaction accepted on stream is registered in the input
//    stage, decoded against the phase register and, if it yields a result,
//    registered in the result register, which drives report.
//  - Throughput: one byte per cycle unless report stalls; the phase register,
//    the 16-bit stop-address sum and the locals increment form the path.
//  - Stall: while report holds an untaken result, an empty input stage still
//    takes one more byte; then stream.ready is low until report.ready returns.
//  - Reset (arst_n low): both stages empty, parser waits for a flags byte,
//    latched header fields clear to zero.
`timescale 1ns / 1ps
module script_header_parser_unit (
	input logic       clk,
	input logic       arst_n,
	shp_in_if.sink    stream,
	shp_out_if.source report
);
	import shp_pkg::*;

	stage_ctl_t ctl;
	in_item_t   item_s1;
	result_t    res;
	logic       res_valid;
	logic       out_free;
	logic       advance;

	// Advance the held byte whenever the result register can take its outcome.
	assign advance = ctl.valid && out_free;

	shp_in_stage u_in_stage (
		.clk              (clk),
		.arst_n           (arst_n),
		.stream           (stream),
		.advance          (advance),
		.ctl_unused_guard (ctl),
		.item_s1          (item_s1)
	);

	// Step the parser once per advanced byte.
	shp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (ctl.advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	// Load only bytes that produce a result; drop the rest silently.
	shp_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && res_valid),
		.res    (res),
		.free   (out_free),
		.report (report)
	);
endmodule
